// File: sv/hvte_pkg.sv
// Package with the shared constants, command type and tag pattern table of the text extractor.
`timescale 1ns / 1ps

package hvte_pkg;

    // Character codes.
    localparam logic [7:0] CH_OPEN  = 8'h3C;
    localparam logic [7:0] CH_CLOSE = 8'h3E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // Tag patterns: bit order of the alive mask.
    localparam int NUM_PAT   = 4;
    localparam int PAT_MAX   = 9;
    localparam logic [3:0] LEN_SAT = 4'd9;

    localparam int PAT_SCRIPT_OPEN  = 0;
    localparam int PAT_SCRIPT_CLOSE = 1;
    localparam int PAT_STYLE_OPEN   = 2;
    localparam int PAT_STYLE_CLOSE  = 3;

    localparam logic [3:0] PAT_LEN [NUM_PAT] = '{4'd7, 4'd8, 4'd6, 4'd7};

    // Default depth of the command queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 4;

    // One command per input beat that yields results.
    typedef struct packed {
        logic       has_space;  // a held space goes out before the byte
        logic       has_byte;   // a text byte goes out; otherwise a bare end marker
        logic [7:0] byte_val;
        logic       last;
    } cmd_t;

    // Character of pattern idx at position pos; zero past the pattern's end.
    function automatic logic [7:0] pat_char(input logic [1:0] idx, input logic [3:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        case (idx)
            2'd0:
            begin
                case (pos)
                    4'd0: ch = "<";
                    4'd1: ch = "s";
                    4'd2: ch = "c";
                    4'd3: ch = "r";
                    4'd4: ch = "i";
                    4'd5: ch = "p";
                    4'd6: ch = "t";
                    default: ch = 8'h00;
                endcase
            end
            2'd1:
            begin
                case (pos)
                    4'd0: ch = "<";
                    4'd1: ch = "/";
                    4'd2: ch = "s";
                    4'd3: ch = "c";
                    4'd4: ch = "r";
                    4'd5: ch = "i";
                    4'd6: ch = "p";
                    4'd7: ch = "t";
                    default: ch = 8'h00;
                endcase
            end
            2'd2:
            begin
                case (pos)
                    4'd0: ch = "<";
                    4'd1: ch = "s";
                    4'd2: ch = "t";
                    4'd3: ch = "y";
                    4'd4: ch = "l";
                    4'd5: ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            default:
            begin
                case (pos)
                    4'd0: ch = "<";
                    4'd1: ch = "/";
                    4'd2: ch = "s";
                    4'd3: ch = "t";
                    4'd4: ch = "y";
                    4'd5: ch = "l";
                    4'd6: ch = "e";
                    default: ch = 8'h00;
                endcase
            end
        endcase
        return ch;
    endfunction

endpackage

// File: sv/hvte_front.sv
// Front end: accepts HTML bytes, tracks tag and skip state, and queues output commands.
`timescale 1ns / 1ps

module hvte_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    input  logic             q_full,
    output logic             push,
    output hvte_pkg::cmd_t   push_cmd
);

    logic       inside_tag_reg, inside_tag_next;
    logic       skip_script_reg, skip_script_next;
    logic       skip_style_reg, skip_style_next;
    logic [3:0] tag_len_reg, tag_len_next;
    logic [3:0] alive_reg, alive_next;
    logic       text_seen_reg, text_seen_next;
    logic       space_pend_reg, space_pend_next;

    logic       accept;
    logic [7:0] lc;
    logic       is_ws;
    logic       emit_byte;
    logic       emit_space;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    // Lower-case A to Z only, and classify whitespace.
    always_comb
    begin
        lc = in_byte;
        if (in_byte >= hvte_pkg::CH_UP_A && in_byte <= hvte_pkg::CH_UP_Z)
        begin
            lc = in_byte + hvte_pkg::CASE_OFS;
        end
        is_ws = (in_byte == hvte_pkg::CH_SPACE) ||
                (in_byte >= hvte_pkg::CH_TAB && in_byte <= hvte_pkg::CH_CR);
    end

    // Next state for one accepted beat.
    always_comb
    begin
        inside_tag_next  = inside_tag_reg;
        skip_script_next = skip_script_reg;
        skip_style_next  = skip_style_reg;
        tag_len_next     = tag_len_reg;
        alive_next       = alive_reg;
        text_seen_next   = text_seen_reg;
        space_pend_next  = space_pend_reg;
        emit_byte        = 1'b0;
        emit_space       = 1'b0;

        if (in_byte == hvte_pkg::CH_OPEN)
        begin
            inside_tag_next = 1'b1;
            tag_len_next    = 4'd1;
            alive_next      = 4'hF;
        end
        else if (inside_tag_reg)
        begin
            // Each pattern drops out on its first mismatch.
            for (int i = 0; i < hvte_pkg::NUM_PAT; i++)
            begin
                if (tag_len_reg < hvte_pkg::PAT_LEN[i] &&
                    hvte_pkg::pat_char(2'(i), tag_len_reg) != lc)
                begin
                    alive_next[i] = 1'b0;
                end
            end
            if (tag_len_reg < hvte_pkg::LEN_SAT)
            begin
                tag_len_next = tag_len_reg + 4'd1;
            end
            if (in_byte == hvte_pkg::CH_CLOSE)
            begin
                inside_tag_next = 1'b0;
                if (alive_next[hvte_pkg::PAT_SCRIPT_OPEN])
                begin
                    skip_script_next = 1'b1;
                end
                else if (alive_next[hvte_pkg::PAT_SCRIPT_CLOSE])
                begin
                    skip_script_next = 1'b0;
                end
                else if (alive_next[hvte_pkg::PAT_STYLE_OPEN])
                begin
                    skip_style_next = 1'b1;
                end
                else if (alive_next[hvte_pkg::PAT_STYLE_CLOSE])
                begin
                    skip_style_next = 1'b0;
                end
                else if (!skip_script_reg && !skip_style_reg && text_seen_reg)
                begin
                    space_pend_next = 1'b1;
                end
            end
        end
        else if (!skip_script_reg && !skip_style_reg)
        begin
            if (is_ws)
            begin
                if (text_seen_reg)
                begin
                    space_pend_next = 1'b1;
                end
            end
            else
            begin
                emit_space      = space_pend_reg;
                emit_byte       = 1'b1;
                space_pend_next = 1'b0;
                text_seen_next  = 1'b1;
            end
        end

        // End of document: everything goes back to its reset value.
        if (in_last)
        begin
            inside_tag_next  = 1'b0;
            skip_script_next = 1'b0;
            skip_style_next  = 1'b0;
            tag_len_next     = 4'd0;
            alive_next       = 4'hF;
            text_seen_next   = 1'b0;
            space_pend_next  = 1'b0;
        end
    end

    // Command for the back end; a last beat with no text makes an end marker.
    always_comb
    begin
        push               = accept && (emit_byte || in_last);
        push_cmd.has_space = emit_space;
        push_cmd.has_byte  = emit_byte;
        push_cmd.byte_val  = emit_byte ? in_byte : 8'h00;
        push_cmd.last      = in_last;
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_tag_reg  <= 1'b0;
            skip_script_reg <= 1'b0;
            skip_style_reg  <= 1'b0;
            tag_len_reg     <= 4'd0;
            alive_reg       <= 4'hF;
            text_seen_reg   <= 1'b0;
            space_pend_reg  <= 1'b0;
        end
        else if (accept)
        begin
            inside_tag_reg  <= inside_tag_next;
            skip_script_reg <= skip_script_next;
            skip_style_reg  <= skip_style_next;
            tag_len_reg     <= tag_len_next;
            alive_reg       <= alive_next;
            text_seen_reg   <= text_seen_next;
            space_pend_reg  <= space_pend_next;
        end
    end

endmodule

// File: sv/hvte_queue.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module hvte_queue
#(
    parameter int DEPTH = hvte_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  hvte_pkg::cmd_t push_cmd,
    input  logic           pop,
    output hvte_pkg::cmd_t head,
    output logic           empty,
    output logic           full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    hvte_pkg::cmd_t slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == FULL_CNT);
    assign head  = slot_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: sv/hvte_back.sv
// Back end: expands queued commands into result beats through an output register.
`timescale 1ns / 1ps

module hvte_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  hvte_pkg::cmd_t head,
    input  logic           empty,
    output logic           pop,
    output logic           res_valid,
    input  logic           res_stall,
    output logic [7:0]     out_byte,
    output logic           out_valid,
    output logic           out_last
);

    logic       res_valid_reg, res_valid_next;
    logic       phase_reg, phase_next;
    logic [7:0] byte_reg, byte_next;
    logic       text_reg, text_next;
    logic       last_reg, last_next;
    logic       load;

    assign res_valid = res_valid_reg;
    assign out_byte  = byte_reg;
    assign out_valid = text_reg;
    assign out_last  = last_reg;

    // The output register takes a new beat when it is empty or being drained.
    assign load = !res_valid_reg || !res_stall;

    // Choose the next beat: held space first, then the byte or end marker.
    always_comb
    begin
        res_valid_next = res_valid_reg;
        phase_next     = phase_reg;
        byte_next      = byte_reg;
        text_next      = text_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        if (load)
        begin
            res_valid_next = 1'b0;
            if (!empty)
            begin
                res_valid_next = 1'b1;
                if (head.has_space && !phase_reg)
                begin
                    byte_next  = hvte_pkg::CH_SPACE;
                    text_next  = 1'b1;
                    last_next  = 1'b0;
                    phase_next = 1'b1;
                end
                else
                begin
                    byte_next  = head.byte_val;
                    text_next  = head.has_byte;
                    last_next  = head.last;
                    phase_next = 1'b0;
                    pop        = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            phase_reg     <= phase_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        text_reg <= text_next;
        last_reg <= last_next;
    end

endmodule

// File: sv/html_visible_text_extractor.sv
// Top level of the HTML visible text extractor: front end, command queue and back end.
//
//  Channel | Beat signals                     | Handshake
//  --------+----------------------------------+----------------------
//  input   | in_byte, in_last                 | in_valid / in_stall
//  result  | out_byte, out_valid, out_last    | res_valid / res_stall
//
// The front end takes one byte every cycle while the command queue has room.
// A byte's first result goes through the command queue into the output
// register; a byte that follows a held space yields two beats, the space
// and then the byte, both from the single output register of the back end.
// Reset is asynchronous and active low and clears all control state at once.
// A stall on the result side fills the queue, and then in_stall rises.
`timescale 1ns / 1ps

module html_visible_text_extractor
#(
    parameter int QUEUE_DEPTH = hvte_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [7:0] out_byte,
    output logic       out_valid,
    output logic       out_last
);

    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_empty;
    hvte_pkg::cmd_t push_cmd;
    hvte_pkg::cmd_t head;

    hvte_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    hvte_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    hvte_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (q_empty),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .out_byte  (out_byte),
        .out_valid (out_valid),
        .out_last  (out_last)
    );

    // A bare end marker always closes a document.
    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !out_valid) |-> out_last)
        else $error("end marker without out_last");

    // A space is only ever a held space, which is never the final beat.
    a_space_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && out_valid && out_byte == hvte_pkg::CH_SPACE) |-> !out_last)
        else $error("space beat marked last");

    // The back end never pops an empty queue.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty)
        else $error("pop from empty command queue");

endmodule
